/* rtl/core/three_operand_alu_with_registers_macros.svh */
// Assertion macros for the three-operand ALU.
// Each macro expects i_clk and i_rst_n in the module that uses it.
`ifndef THREE_OPERAND_ALU_WITH_REGISTERS_MACROS_SVH
`define THREE_OPERAND_ALU_WITH_REGISTERS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOALU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOALU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/toalu_pkg.sv */
// Package for the three-operand ALU: widths, opcodes, item and control types.
// No dependencies; every other file of the block but the macros header imports it.
`timescale 1ns / 1ps

package toalu_pkg;

    localparam int DATA_W       = 32;
    localparam int OPC_W        = 4;
    localparam int NUM_REGS_DEF = 16;
    localparam int ITER_STEPS   = DATA_W;
    localparam int CNT_W        = $clog2(ITER_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITER_STEPS - 1);

    typedef enum logic [OPC_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_DIV = 4'd2,
        OP_MUL = 4'd3,
        OP_LSL = 4'd4,
        OP_LSR = 4'd5,
        OP_ASR = 4'd6,
        OP_AND = 4'd7,
        OP_ORR = 4'd8,
        OP_EOR = 4'd9,
        OP_NOT = 4'd10,
        OP_MOV = 4'd11
    } t_opcode;

    typedef enum logic [1:0] {
        SEL_A = 2'd0,
        SEL_B = 2'd1,
        SEL_C = 2'd2
    } t_opsel;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [DATA_W-1:0] operand_c;
        logic              a_is_reg;
        logic              b_is_reg;
        logic              c_is_reg;
    } t_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load;
        logic   rd_en;
        t_opsel rd_sel;
        logic   cap_en;
        t_opsel cap_sel;
        logic   iter_start;
        logic   iter_step;
        logic   wr_en;
        logic   out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_mov;
        logic is_iter;
        logic iter_last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/core/toalu_if.sv */
// Valid/ready channel interfaces for the item and result streams.
// Depends on toalu_pkg for the field widths.
`timescale 1ns / 1ps

interface toalu_in_if;
    import toalu_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [DATA_W-1:0] operand_c;
    logic              a_is_reg;
    logic              b_is_reg;
    logic              c_is_reg;

    modport source (
        output valid, opcode, operand_a, operand_b, operand_c,
        output a_is_reg, b_is_reg, c_is_reg,
        input  ready
    );
    modport sink (
        input  valid, opcode, operand_a, operand_b, operand_c,
        input  a_is_reg, b_is_reg, c_is_reg,
        output ready
    );
endinterface

interface toalu_out_if;
    import toalu_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result_value;
    logic              overflow;

    modport source (output valid, result_value, overflow, input ready);
    modport sink (input valid, result_value, overflow, output ready);
endinterface

/* rtl/core/three_operand_alu_with_registers.sv */
// Channel     | Dir | Payload                                          | Handshake
// i_in        | in  | opcode, operand_a/b/c, a_is_reg/b_is_reg/c_is_reg | valid/ready
// o_out       | out | result_value, overflow                           | valid/ready
//
// Each item passes, from one acceptance to the next, through states IDLE (accept),
// RDA, RDB, RDC (three reads on the single register-file read port), CAP and DONE
// (load); RDB to CAP capture operands; DIV and MUL add ITER on the bit-serial unit.
// After reset the register file reads as zero through per-entry valid bits;
// there is no clearing pass. The output register holds one result, so a new
// item is taken while it waits; only a second finished result stalls.
// Top level of the three-operand ALU; depends on toalu_pkg, the channel
// interfaces, toalu_ctrl and toalu_dp.
`timescale 1ns / 1ps

module three_operand_alu_with_registers #(
    parameter int NUM_REGS = toalu_pkg::NUM_REGS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    toalu_in_if.sink    i_in,
    toalu_out_if.source o_out
);
    import toalu_pkg::*;

    t_cmd  w_cmd;
    t_sts  w_sts;
    t_item w_item;
    logic  w_in_ready;

    assign w_item.opcode    = i_in.opcode;
    assign w_item.operand_a = i_in.operand_a;
    assign w_item.operand_b = i_in.operand_b;
    assign w_item.operand_c = i_in.operand_c;
    assign w_item.a_is_reg  = i_in.a_is_reg;
    assign w_item.b_is_reg  = i_in.b_is_reg;
    assign w_item.c_is_reg  = i_in.c_is_reg;
    assign i_in.ready       = w_in_ready;

    toalu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    toalu_dp #(
        .NUM_REGS (NUM_REGS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (w_item),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result_value (o_out.result_value),
        .o_overflow     (o_out.overflow)
    );

endmodule

/* rtl/core/toalu_ctrl.sv */
// Controller state machine: sequences operand fetch, iteration and result load.
// Depends on toalu_pkg for the command and status types.
`timescale 1ns / 1ps

module toalu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  toalu_pkg::t_sts  i_sts,
    output toalu_pkg::t_cmd  o_cmd
);
    import toalu_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RDA  = 7'b0000010,
        ST_RDB  = 7'b0000100,
        ST_RDC  = 7'b0001000,
        ST_CAP  = 7'b0010000,
        ST_ITER = 7'b0100000,
        ST_DONE = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RDA;
                end
            end
            ST_RDA: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = SEL_A;
                n_state      = ST_RDB;
            end
            ST_RDB: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = SEL_A;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = SEL_B;
                n_state       = ST_RDC;
            end
            ST_RDC: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = SEL_B;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = SEL_C;
                n_state       = ST_CAP;
            end
            ST_CAP: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = SEL_C;
                if (i_sts.is_mov) begin
                    o_cmd.wr_en = 1'b1;
                    n_state     = ST_DONE;
                end else if (i_sts.is_iter) begin
                    o_cmd.iter_start = 1'b1;
                    n_state          = ST_ITER;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_ITER: begin
                o_cmd.iter_step = 1'b1;
                if (i_sts.iter_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/toalu_dp.sv */
// Datapath: item register, register file, shift-add multiplier, restoring
// divider, result selection and output register. Depends on toalu_pkg.
`timescale 1ns / 1ps
`include "three_operand_alu_with_registers_macros.svh"

module toalu_dp #(
    parameter int NUM_REGS = toalu_pkg::NUM_REGS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  toalu_pkg::t_item              i_item,
    input  toalu_pkg::t_cmd               i_cmd,
    output toalu_pkg::t_sts               o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [toalu_pkg::DATA_W-1:0]  o_result_value,
    output logic                          o_overflow
);
    import toalu_pkg::*;

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam logic [DATA_W-1:0] NREGS = DATA_W'(NUM_REGS);

    t_item             r_item;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_c;

    // Register file with one read and one write port; valid bits give the
    // all-zero contents after reset.
    logic [DATA_W-1:0] r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [DATA_W-1:0] r_rd_data;
    logic              r_rd_ok;

    logic [DATA_W-1:0] w_rd_raw;
    logic              w_rd_inrange;
    logic [IDX_W-1:0]  w_rd_idx;
    logic [DATA_W-1:0] w_fetched;
    logic              w_wr_ok;
    logic [IDX_W-1:0]  w_wr_idx;

    logic [DATA_W-1:0] r_x;
    logic [DATA_W-1:0] r_y;
    logic [DATA_W-1:0] r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              w_is_div;
    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_trial_diff;

    logic [DATA_W+1:0] w_sum;
    logic [DATA_W:0]   w_sub;
    logic [DATA_W-1:0] w_res;
    logic              w_ovf;

    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // Read port address.
    always_comb begin
        unique case (i_cmd.rd_sel)
            SEL_A:   w_rd_raw = r_item.operand_a;
            SEL_B:   w_rd_raw = r_item.operand_b;
            default: w_rd_raw = r_item.operand_c;
        endcase
    end

    assign w_rd_inrange = (w_rd_raw < NREGS);
    assign w_rd_idx     = w_rd_raw[IDX_W-1:0];
    assign w_fetched    = r_rd_ok ? r_rd_data : '0;

    // A MOV only writes when the destination is flagged as a register and in range.
    assign w_wr_ok  = i_cmd.wr_en && r_item.a_is_reg && (r_item.operand_a < NREGS);
    assign w_wr_idx = r_item.operand_a[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en && w_rd_inrange) begin
            r_rd_data <= r_mem[w_rd_idx];
        end
        if (w_wr_ok) begin
            r_mem[w_wr_idx] <= r_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.rd_en) begin
                r_rd_ok <= w_rd_inrange && r_vld[w_rd_idx];
            end
            if (w_wr_ok) begin
                r_vld[w_wr_idx] <= 1'b1;
            end
        end
    end

    // Operand capture, one per cycle, in the cycle after its read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            unique case (i_cmd.cap_sel)
                SEL_A:   r_a <= r_item.a_is_reg ? w_fetched : r_item.operand_a;
                SEL_B:   r_b <= r_item.b_is_reg ? w_fetched : r_item.operand_b;
                default: r_c <= r_item.c_is_reg ? w_fetched : r_item.operand_c;
            endcase
        end
    end

    // Shared iterative unit: one bit per cycle of either a shift-add
    // multiply or a restoring divide.
    assign w_is_div     = (r_item.opcode == OP_DIV);
    assign w_trial      = {r_x, r_y[DATA_W-1]};
    assign w_trial_diff = w_trial - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.iter_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (i_cmd.iter_step && r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.iter_start) begin
            r_acc <= '0;
            if (w_is_div) begin
                r_x <= '0;
                r_y <= r_a;
            end else begin
                r_x <= r_a;
                r_y <= r_b;
            end
        end else if (i_cmd.iter_step && r_busy) begin
            if (w_is_div) begin
                if (!w_trial_diff[DATA_W]) begin
                    r_x <= w_trial_diff[DATA_W-1:0];
                    r_y <= {r_y[DATA_W-2:0], 1'b1};
                end else begin
                    r_x <= w_trial[DATA_W-1:0];
                    r_y <= {r_y[DATA_W-2:0], 1'b0};
                end
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= {r_x[DATA_W-2:0], 1'b0};
                r_y <= {1'b0, r_y[DATA_W-1:1]};
            end
        end
    end

    // Result selection.
    assign w_sum = {2'b00, r_a} + {2'b00, r_b} + {2'b00, r_c};
    assign w_sub = {1'b0, r_a} - {1'b0, r_b};

    always_comb begin
        w_ovf = 1'b0;
        unique case (r_item.opcode)
            OP_ADD: begin
                w_res = w_sum[DATA_W-1:0];
                w_ovf = |w_sum[DATA_W+1:DATA_W];
            end
            OP_SUB: begin
                w_res = w_sub[DATA_W-1:0];
                w_ovf = w_sub[DATA_W];
            end
            OP_DIV:  w_res = (r_b == '0) ? '0 : r_y;
            OP_MUL:  w_res = r_acc;
            OP_LSL:  w_res = {r_a[DATA_W-2:0], 1'b0};
            OP_LSR:  w_res = {1'b0, r_a[DATA_W-1:1]};
            OP_ASR:  w_res = {r_a[DATA_W-1], r_a[DATA_W-1:1]};
            OP_AND:  w_res = r_a & r_b;
            OP_ORR:  w_res = r_a | r_b;
            OP_EOR:  w_res = r_a ^ r_b;
            OP_NOT:  w_res = ~r_a;
            OP_MOV:  w_res = r_b;
            default: w_res = '0;
        endcase
    end

    // Output register: holds one result so the next item can start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= w_res;
            r_out_ovf   <= w_ovf;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_value = r_out_value;
    assign o_overflow     = r_out_ovf;

    assign o_sts.is_mov    = (r_item.opcode == OP_MOV);
    assign o_sts.is_iter   = w_is_div || (r_item.opcode == OP_MUL);
    assign o_sts.iter_last = r_busy && (r_cnt == CNT_LAST);
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    `TOALU_ASSERT_SAME(a_wr_only_mov, i_cmd.wr_en, r_item.opcode == OP_MOV, "write for non-MOV")
    `TOALU_ASSERT_SAME(a_load_safe, i_cmd.out_load, (!r_out_vld || i_out_ready) && !r_busy, "result overwritten or early")
    `TOALU_ASSERT_SAME(a_accept_idle, i_cmd.load, !r_busy, "item accepted mid-iteration")
    `TOALU_ASSERT_NEXT(a_start_busy, i_cmd.iter_start, r_busy && (r_cnt == '0), "iteration did not start")

endmodule

/* dv/tb.sv */
// Self-checking bench for three_operand_alu_with_registers: directed rows, then random items.
// Results are checked in order against typed expectations or a shadow register file and ALU predictor.
// Depends on toalu_pkg, the channel interfaces in toalu_if.sv and the top-level RTL.
`timescale 1ns / 1ps

module tb;
    import toalu_pkg::*;

    localparam int NREGS         = NUM_REGS_DEF;
    localparam int IDX_W         = $clog2(NREGS);
    localparam int RANDOM_ITEMS  = 1700;
    localparam int CALM_TAIL     = 250;
    localparam int DRAIN_CYCLES  = 40;
    localparam int QUIET_LIMIT   = 4000;
    localparam logic [OPC_W-1:0] OP_UNUSED_LO = 4'd12;
    localparam logic [OPC_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ovf;
    } t_alu_result;

    typedef struct packed {
        t_item       item;
        logic        typed;
        t_alu_result want;
    } t_vector;

    logic i_clk = 1'b0;
    logic i_rst_n;

    toalu_in_if  in_ch ();
    toalu_out_if out_ch ();

    three_operand_alu_with_registers u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    logic [DATA_W-1:0] reg_shadow [NREGS];
    t_alu_result       pending_results [$];
    int                fail_count = 0;
    int                idle_odds  = 0;

    initial begin
        for (int k = 0; k < NREGS; k++) reg_shadow[k] = '0;
    end

    function automatic logic [DATA_W-1:0] fetch_operand(input logic [DATA_W-1:0] raw,
                                                        input logic is_reg);
        if (!is_reg) return raw;
        if (raw < NREGS) return reg_shadow[raw[IDX_W-1:0]];
        return '0;
    endfunction

    // Works out the result of one instruction and applies any register write.
    function automatic t_alu_result predict_alu(input t_item it);
        t_alu_result         r;
        logic [DATA_W-1:0]   a, b, c;
        logic [DATA_W+1:0]   sum;
        logic [2*DATA_W-1:0] prod;
        r = '0;
        b = fetch_operand(it.operand_b, it.b_is_reg);
        if (it.opcode == OP_MOV) begin
            // The destination is only written when it is flagged and in range.
            if (it.a_is_reg && it.operand_a < NREGS) reg_shadow[it.operand_a[IDX_W-1:0]] = b;
            r.value = b;
            return r;
        end
        a = fetch_operand(it.operand_a, it.a_is_reg);
        c = fetch_operand(it.operand_c, it.c_is_reg);
        case (it.opcode)
            OP_ADD: begin
                sum     = {2'b00, a} + {2'b00, b} + {2'b00, c};
                r.value = sum[DATA_W-1:0];
                r.ovf   = |sum[DATA_W+1:DATA_W];
            end
            OP_SUB: begin
                r.value = a - b;
                r.ovf   = (b > a);
            end
            OP_DIV: r.value = (b != '0) ? a / b : '0;
            OP_MUL: begin
                prod    = (2*DATA_W)'(a) * (2*DATA_W)'(b);
                r.value = prod[DATA_W-1:0];
            end
            OP_LSL: r.value = {a[DATA_W-2:0], 1'b0};
            OP_LSR: r.value = {1'b0, a[DATA_W-1:1]};
            OP_ASR: r.value = {a[DATA_W-1], a[DATA_W-1:1]};
            OP_AND: r.value = a & b;
            OP_ORR: r.value = a | b;
            OP_EOR: r.value = a ^ b;
            OP_NOT: r.value = ~a;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_vector vec(input logic [OPC_W-1:0] op, input logic [DATA_W-1:0] a,
                                    input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] c,
                                    input logic [2:0] flags, input int typed,
                                    input logic [DATA_W-1:0] val, input int ovf);
        t_vector v;
        v.item       = '{op, a, b, c, flags[2], flags[1], flags[0]};
        v.typed      = (typed != 0);
        v.want.value = val;
        v.want.ovf   = (ovf != 0);
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'h0000_0001;
            2:       return '1;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5, 6:    return DATA_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // Mostly valid register numbers, with some just past the end and some wild.
    function automatic logic [DATA_W-1:0] rand_index();
        case ($urandom_range(0, 19))
            0:       return DATA_W'($urandom_range(NREGS, NREGS + 3));
            1:       return $urandom;
            default: return DATA_W'($urandom_range(0, NREGS - 1));
        endcase
    endfunction

    function automatic t_item rand_instr();
        t_item it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 22)
            it.opcode = OP_MOV;
        else if (pick < 26)
            it.opcode = OPC_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else
            it.opcode = OPC_W'($urandom_range(OP_ADD, OP_NOT));
        if (it.opcode == OP_MOV)
            it.a_is_reg = ($urandom_range(0, 9) != 0);
        else
            it.a_is_reg = 1'($urandom_range(0, 1));
        it.b_is_reg  = 1'($urandom_range(0, 1));
        it.c_is_reg  = 1'($urandom_range(0, 1));
        it.operand_a = it.a_is_reg ? rand_index() : rand_word();
        it.operand_b = it.b_is_reg ? rand_index() : rand_word();
        it.operand_c = it.c_is_reg ? rand_index() : rand_word();
        return it;
    endfunction

    task automatic send_item(input t_item it, input logic typed, input t_alu_result want);
        t_alu_result prediction;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.opcode    <= it.opcode;
        in_ch.operand_a <= it.operand_a;
        in_ch.operand_b <= it.operand_b;
        in_ch.operand_c <= it.operand_c;
        in_ch.a_is_reg  <= it.a_is_reg;
        in_ch.b_is_reg  <= it.b_is_reg;
        in_ch.c_is_reg  <= it.c_is_reg;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        // The shadow state must advance even when the expectation is typed in.
        prediction = predict_alu(it);
        if (typed) begin
            pending_results = {pending_results, want};
        end else begin
            pending_results = {pending_results, prediction};
        end
    endtask

    // Stimulus: reset, the directed table, then random items.
    initial begin
        t_vector     rows [$];
        t_alu_result none;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.opcode    <= '0;
        in_ch.operand_a <= '0;
        in_ch.operand_b <= '0;
        in_ch.operand_c <= '0;
        in_ch.a_is_reg  <= 1'b0;
        in_ch.b_is_reg  <= 1'b0;
        in_ch.c_is_reg  <= 1'b0;
        none = '0;

        rows = {rows, vec(OP_ADD, 0, 5, 15, 3'b111, 1, 32'h0000_0000, 0)};
        rows = {rows, vec(OP_ADD, '1, '1, '1, 3'b000, 1, 32'hFFFF_FFFD, 1)};
        rows = {rows, vec(OP_ADD, '1, 1, 0, 3'b000, 1, 32'h0000_0000, 1)};
        rows = {rows, vec(OP_SUB, 0, 1, '1, 3'b000, 1, 32'hFFFF_FFFF, 1)};
        rows = {rows, vec(OP_SUB, '1, '1, 0, 3'b000, 1, 32'h0000_0000, 0)};
        rows = {rows, vec(OP_DIV, 7, 0, '1, 3'b000, 1, 32'h0000_0000, 0)};
        rows = {rows, vec(OP_DIV, '1, 1, 0, 3'b000, 1, 32'hFFFF_FFFF, 0)};
        rows = {rows, vec(OP_DIV, '1, '1, 0, 3'b000, 1, 32'h0000_0001, 0)};
        rows = {rows, vec(OP_MUL, '1, '1, 0, 3'b000, 1, 32'h0000_0001, 0)};
        rows = {rows, vec(OP_LSL, 32'h8000_0001, '1, '1, 3'b000, 1, 32'h0000_0002, 0)};
        rows = {rows, vec(OP_LSR, 32'h8000_0001, '1, '1, 3'b000, 1, 32'h4000_0000, 0)};
        rows = {rows, vec(OP_ASR, 32'h8000_0001, 0, 0, 3'b000, 1, 32'hC000_0000, 0)};
        rows = {rows, vec(OP_ASR, 32'h7FFF_FFFF, 0, 0, 3'b000, 1, 32'h3FFF_FFFF, 0)};
        rows = {rows, vec(OP_AND, '1, 0, '1, 3'b000, 1, 32'h0000_0000, 0)};
        rows = {rows, vec(OP_ORR, 0, '1, 0, 3'b000, 1, 32'hFFFF_FFFF, 0)};
        rows = {rows, vec(OP_EOR, 32'hAAAA_AAAA, '1, 0, 3'b000, 1, 32'h5555_5555, 0)};
        rows = {rows, vec(OP_NOT, 0, '1, '1, 3'b000, 1, 32'hFFFF_FFFF, 0)};
        rows = {rows, vec(OP_MOV, 3, 32'hDEAD_BEEF, 0, 3'b100, 1, 32'hDEAD_BEEF, 0)};
        rows = {rows, vec(OP_MOV, 15, 3, 0, 3'b110, 0, 0, 0)};
        // A destination past the end of the file and an unflagged one write nothing.
        rows = {rows, vec(OP_MOV, NREGS, 32'h1234_5678, 0, 3'b100, 1, 32'h1234_5678, 0)};
        rows = {rows, vec(OP_MOV, 4, 1, 0, 3'b000, 1, 32'h0000_0001, 0)};
        rows = {rows, vec(OP_ADD, 3, 15, 4, 3'b111, 0, 0, 0)};
        rows = {rows, vec(OP_ORR, '1, 32'h5A5A_5A5A, 0, 3'b100, 1, 32'h5A5A_5A5A, 0)};
        rows = {rows, vec(OP_UNUSED_LO, '1, '1, '1, 3'b000, 1, 32'h0000_0000, 0)};
        rows = {rows, vec(OP_UNUSED_HI, 3, 15, 3, 3'b111, 1, 32'h0000_0000, 0)};
        rows = {rows, vec(OP_SUB, 15, 1, 0, 3'b100, 0, 0, 0)};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_odds = 6;
        foreach (rows[k]) send_item(rows[k].item, rows[k].typed, rows[k].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - CALM_TAIL) begin
                idle_odds = 0;
            end else if (n % 150 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_odds = 0;
                    1:       idle_odds = 4;
                    default: idle_odds = 12;
                endcase
            end
            send_item(rand_instr(), 1'b0, none);
        end
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Result side: checks each accepted item and applies random back-pressure.
    initial begin
        int          stall_left;
        t_alu_result exp_res;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: result_value %h overflow %b",
                           out_ch.result_value, out_ch.overflow);
                    fail_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (out_ch.result_value !== exp_res.value) begin
                        $error("result_value: expected %h, actual %h",
                               exp_res.value, out_ch.result_value);
                        fail_count++;
                    end
                    if (out_ch.overflow !== exp_res.ovf) begin
                        $error("overflow: expected %b, actual %b",
                               exp_res.ovf, out_ch.overflow);
                        fail_count++;
                    end
                end
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                stall_left = $urandom_range(1, 18) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/toalu_pkg.sv
rtl/core/toalu_if.sv
rtl/core/toalu_ctrl.sv
rtl/core/toalu_dp.sv
rtl/core/three_operand_alu_with_registers.sv
dv/tb.sv
